>>> design/fbeq_pkg.sv
// ----------------------------------------------------------------------------
// fbeq_pkg: shared types and constants of the FFT bin graphic equaliser
// Widths, register indexes, node frequencies and the per-segment constants
// used to interpolate a band gain and divide by the segment span.
// ----------------------------------------------------------------------------
package fbeq_pkg;

    localparam int NUM_STG    = 12;
    localparam int NODE_COUNT = 10;
    localparam int GAIN_W     = 16;
    localparam int HZ_W       = 24;
    localparam int IDX_W      = 12;
    localparam int DATA_W     = 16;
    localparam int TDATA_W    = 48;
    localparam int LOG2_W     = 4;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 64;
    localparam int NODE_F_W   = 27;
    localparam int SPAN_W     = 25;
    localparam int PROD_G_W   = GAIN_W + SPAN_W;
    localparam int NUM_W      = PROD_G_W + 1;
    localparam int NRED_W     = 23;
    localparam int RECIP_W    = 28;
    localparam int RECIP_SH   = 32;
    localparam int DIV_W      = 7;
    localparam int SHIFT_W    = 5;
    localparam int TOTAL_W    = 2 * GAIN_W;
    localparam int SCALED_W   = DATA_W + TOTAL_W;
    localparam int ROUND_SH   = 24;

    // Register indexes of the configuration port
    localparam logic [CFG_ADDR_W-1:0] REG_MASTER_GAIN = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_BAND_LOW    = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_BAND_MID    = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_BAND_HIGH   = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_HZ_PER_BIN  = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_FFT_LOG2    = 3'd5;

    // Segment codes: below the first node, interpolation segments 1..10,
    // 10 being the ramp from the top node down to zero, and above the top
    localparam int SEG_W = 4;
    localparam logic [SEG_W-1:0] SEG_BELOW    = 4'd0;
    localparam logic [SEG_W-1:0] SEG_TOP_RAMP = 4'd10;
    localparam logic [SEG_W-1:0] SEG_ABOVE    = 4'd11;

    // Node frequencies in Q.12 Hz
    localparam logic [NODE_F_W-1:0] NODE_FREQ [NODE_COUNT] = '{
        27'd129024,   27'd258048,   27'd512000,   27'd1024000,  27'd2048000,
        27'd4096000,  27'd8192000,  27'd16384000, 27'd32768000, 27'd65536000
    };
    localparam logic [NODE_F_W-1:0] TOP_FREQ = 27'd81920000;

    typedef struct packed {
        logic [IDX_W-1:0]  idx;
        logic [DATA_W-1:0] re;
        logic [DATA_W-1:0] im;
        logic [DATA_W-1:0] mag_re;
        logic [DATA_W-1:0] mag_im;
        logic              kzero;
    } side_t;

    // Lower node frequency of a segment
    function automatic logic [NODE_F_W-1:0] seg_flo(input logic [SEG_W-1:0] seg);
        logic [NODE_F_W-1:0] r;
        case (seg)
            4'd1:         r = 27'd129024;
            4'd2:         r = 27'd258048;
            4'd3:         r = 27'd512000;
            4'd4:         r = 27'd1024000;
            4'd5:         r = 27'd2048000;
            4'd6:         r = 27'd4096000;
            4'd7:         r = 27'd8192000;
            4'd8:         r = 27'd16384000;
            4'd9:         r = 27'd32768000;
            SEG_TOP_RAMP: r = 27'd65536000;
            default:      r = '0;
        endcase
        return r;
    endfunction

    // Span of a segment = 2^shift * divisor
    function automatic logic [SPAN_W-1:0] seg_span(input logic [SEG_W-1:0] seg);
        logic [SPAN_W-1:0] r;
        case (seg)
            4'd1:         r = 25'd129024;
            4'd2:         r = 25'd253952;
            4'd3:         r = 25'd512000;
            4'd4:         r = 25'd1024000;
            4'd5:         r = 25'd2048000;
            4'd6:         r = 25'd4096000;
            4'd7:         r = 25'd8192000;
            4'd8:         r = 25'd16384000;
            4'd9:         r = 25'd32768000;
            SEG_TOP_RAMP: r = 25'd16384000;
            default:      r = 25'd1;
        endcase
        return r;
    endfunction

    function automatic logic [SHIFT_W-1:0] seg_shift(input logic [SEG_W-1:0] seg);
        logic [SHIFT_W-1:0] r;
        case (seg)
            4'd1:         r = 5'd11;
            4'd2:         r = 5'd13;
            4'd3:         r = 5'd12;
            4'd4:         r = 5'd13;
            4'd5:         r = 5'd14;
            4'd6:         r = 5'd15;
            4'd7:         r = 5'd16;
            4'd8:         r = 5'd17;
            4'd9:         r = 5'd18;
            SEG_TOP_RAMP: r = 5'd17;
            default:      r = 5'd0;
        endcase
        return r;
    endfunction

    function automatic logic [DIV_W-1:0] seg_div(input logic [SEG_W-1:0] seg);
        logic [DIV_W-1:0] r;
        case (seg)
            4'd1:    r = 7'd63;
            4'd2:    r = 7'd31;
            default: r = 7'd125;
        endcase
        return r;
    endfunction

    // floor(2^32 / divisor)
    function automatic logic [RECIP_W-1:0] seg_recip(input logic [SEG_W-1:0] seg);
        logic [RECIP_W-1:0] r;
        case (seg)
            4'd1:    r = 28'd68174084;
            4'd2:    r = 28'd138547332;
            default: r = 28'd34359738;
        endcase
        return r;
    endfunction

endpackage

>>> design/fbeq_fold.sv
// ----------------------------------------------------------------------------
// fbeq_fold: index folding and bin frequency
// Reduces the bin index to the FFT size, folds it about the Nyquist bin and
// multiplies the folded index by the frequency step. Two register stages.
// ----------------------------------------------------------------------------
module fbeq_fold
    import fbeq_pkg::*;
#(
    parameter int MAX_FFT_LOG2 = 12
) (
    input  logic                             aclk,
    input  logic [1:0]                       adv,
    input  logic [LOG2_W-1:0]                fft_log2,
    input  logic [HZ_W-1:0]                  hz_per_bin,
    input  logic [IDX_W-1:0]                 bin_index,
    input  logic [DATA_W-1:0]                real_in,
    input  logic [DATA_W-1:0]                imag_in,
    output side_t                            side_reg,
    output logic [MAX_FFT_LOG2+HZ_W-1:0]     freq_reg
);

    localparam int KW   = MAX_FFT_LOG2;
    localparam int LG_W = $clog2(MAX_FFT_LOG2 + 1);
    localparam int FW   = KW + HZ_W;

    logic [LG_W-1:0] lg;
    logic [KW:0]     size;
    logic [KW:0]     mask;
    logic [KW-1:0]   k_raw;
    logic [KW-1:0]   k_next;
    logic [KW-1:0]   k_reg;
    side_t           side_next;
    logic [FW-1:0]   freq_next;

    always_comb begin
        if (fft_log2 < 4'd2) begin
            lg = LG_W'(2);
        end else if (int'(fft_log2) > MAX_FFT_LOG2) begin
            lg = LG_W'(MAX_FFT_LOG2);
        end else begin
            lg = LG_W'(fft_log2);
        end
        size  = (KW+1)'(1) << lg;
        mask  = size - (KW+1)'(1);
        k_raw = KW'(bin_index) & mask[KW-1:0];
        // fold the upper half back onto the lower one
        if ({1'b0, k_raw} >= (size >> 1)) begin
            k_next = KW'(size - {1'b0, k_raw});
        end else begin
            k_next = k_raw;
        end

        side_next.idx    = bin_index;
        side_next.re     = real_in;
        side_next.im     = imag_in;
        side_next.mag_re = real_in[DATA_W-1] ? (~real_in + 16'd1) : real_in;
        side_next.mag_im = imag_in[DATA_W-1] ? (~imag_in + 16'd1) : imag_in;
        side_next.kzero  = (k_raw == '0);
    end

    assign freq_next = FW'(k_reg * hz_per_bin);

    always_ff @(posedge aclk) begin
        if (adv[0]) begin
            k_reg    <= k_next;
            side_reg <= side_next;
        end
        if (adv[1]) begin
            freq_reg <= freq_next;
        end
    end

endmodule

>>> design/fbeq_gain.sv
// ----------------------------------------------------------------------------
// fbeq_gain: band gain by interpolation between octave nodes
// Finds the segment of the bin frequency, forms the weighted node gains and
// divides by the segment span: power-of-two shift, then a reciprocal
// multiply with one correction step. Seven register stages.
// ----------------------------------------------------------------------------
module fbeq_gain
    import fbeq_pkg::*;
#(
    parameter int FW = 36
) (
    input  logic                             aclk,
    input  logic [6:0]                       adv,
    input  logic [FW-1:0]                    freq,
    input  logic [NODE_COUNT*GAIN_W-1:0]     node_gains,
    output logic [GAIN_W-1:0]                gain_reg
);

    // stage 2: segment
    logic [SEG_W-1:0]    seg_s2_next, seg_s2_reg;
    logic [NODE_F_W-1:0] f_s2_reg;
    // stage 3: distances and node gains
    logic [SEG_W-1:0]    seg_s3_reg;
    logic [NODE_F_W-1:0] d_full;
    logic [SPAN_W-1:0]   d_s3_next, d_s3_reg;
    logic [SPAN_W-1:0]   smd_s3_next, smd_s3_reg;
    logic [GAIN_W-1:0]   glo_s3_next, glo_s3_reg;
    logic [GAIN_W-1:0]   ghi_s3_next, ghi_s3_reg;
    logic [SEG_W-1:0]    lo_sel, hi_sel;
    // stage 4: weighted products
    logic [SEG_W-1:0]    seg_s4_reg;
    logic [PROD_G_W-1:0] plo_s4_reg, phi_s4_reg;
    // stage 5: numerator, reduced by the power-of-two part of the span
    logic [SEG_W-1:0]    seg_s5_reg;
    logic [NUM_W-1:0]    num;
    logic [NRED_W-1:0]   nred_s5_next, nred_s5_reg;
    // stage 6: reciprocal estimate
    logic [SEG_W-1:0]    seg_s6_reg;
    logic [NRED_W-1:0]   nred_s6_reg;
    logic [NRED_W+RECIP_W-1:0] recip_prod;
    logic [GAIN_W-1:0]   q0_s6_next, q0_s6_reg;
    // stage 7: back-multiply
    logic [SEG_W-1:0]    seg_s7_reg;
    logic [NRED_W-1:0]   nred_s7_reg;
    logic [GAIN_W-1:0]   q0_s7_reg;
    logic [NRED_W-1:0]   back_s7_next, back_s7_reg;
    // stage 8: correction and gain select
    logic [NRED_W-1:0]   rem;
    logic [GAIN_W-1:0]   quo;
    logic [GAIN_W-1:0]   gain_next;

    always_comb begin
        seg_s2_next = SEG_BELOW;
        for (int n = 0; n < NODE_COUNT; n++) begin
            if (freq > FW'(NODE_FREQ[n])) begin
                seg_s2_next = SEG_W'(n + 1);
            end
        end
        if (freq >= FW'(TOP_FREQ)) begin
            seg_s2_next = SEG_ABOVE;
        end
    end

    always_comb begin
        d_full      = f_s2_reg - seg_flo(seg_s2_reg);
        d_s3_next   = d_full[SPAN_W-1:0];
        smd_s3_next = seg_span(seg_s2_reg) - d_s3_next;
        if (seg_s2_reg == SEG_BELOW || seg_s2_reg == SEG_ABOVE) begin
            lo_sel = '0;
        end else begin
            lo_sel = seg_s2_reg - 4'd1;
        end
        if (seg_s2_reg == SEG_BELOW || seg_s2_reg == SEG_ABOVE
                || seg_s2_reg == SEG_TOP_RAMP) begin
            hi_sel = '0;
        end else begin
            hi_sel = seg_s2_reg;
        end
        glo_s3_next = node_gains[GAIN_W*lo_sel +: GAIN_W];
        // the ramp above the top node runs down to zero
        ghi_s3_next = (seg_s2_reg == SEG_TOP_RAMP) ? '0
                                                    : node_gains[GAIN_W*hi_sel +: GAIN_W];
    end

    always_comb begin
        num = NUM_W'(plo_s4_reg) + NUM_W'(phi_s4_reg)
              + NUM_W'(seg_span(seg_s4_reg) >> 1);
        nred_s5_next = NRED_W'(num >> seg_shift(seg_s4_reg));
    end

    assign recip_prod   = nred_s5_reg * seg_recip(seg_s5_reg);
    assign q0_s6_next   = recip_prod[RECIP_SH+GAIN_W-1:RECIP_SH];
    assign back_s7_next = NRED_W'(q0_s6_reg * seg_div(seg_s6_reg));

    always_comb begin
        rem = nred_s7_reg - back_s7_reg;
        // the estimate is at most one short
        if (rem >= NRED_W'(seg_div(seg_s7_reg))) begin
            quo = q0_s7_reg + 16'd1;
        end else begin
            quo = q0_s7_reg;
        end
        if (seg_s7_reg == SEG_BELOW) begin
            gain_next = node_gains[GAIN_W-1:0];
        end else if (seg_s7_reg == SEG_ABOVE) begin
            gain_next = '0;
        end else begin
            gain_next = quo;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv[0]) begin
            seg_s2_reg <= seg_s2_next;
            f_s2_reg   <= freq[NODE_F_W-1:0];
        end
        if (adv[1]) begin
            seg_s3_reg <= seg_s2_reg;
            d_s3_reg   <= d_s3_next;
            smd_s3_reg <= smd_s3_next;
            glo_s3_reg <= glo_s3_next;
            ghi_s3_reg <= ghi_s3_next;
        end
        if (adv[2]) begin
            seg_s4_reg <= seg_s3_reg;
            plo_s4_reg <= glo_s3_reg * smd_s3_reg;
            phi_s4_reg <= ghi_s3_reg * d_s3_reg;
        end
        if (adv[3]) begin
            seg_s5_reg  <= seg_s4_reg;
            nred_s5_reg <= nred_s5_next;
        end
        if (adv[4]) begin
            seg_s6_reg  <= seg_s5_reg;
            nred_s6_reg <= nred_s5_reg;
            q0_s6_reg   <= q0_s6_next;
        end
        if (adv[5]) begin
            seg_s7_reg  <= seg_s6_reg;
            nred_s7_reg <= nred_s6_reg;
            q0_s7_reg   <= q0_s6_reg;
            back_s7_reg <= back_s7_next;
        end
        if (adv[6]) begin
            gain_reg <= gain_next;
        end
    end

endmodule

>>> design/fbeq_scale.sv
// ----------------------------------------------------------------------------
// fbeq_scale: scaling of both bin parts
// Forms master times band gain, scales the magnitudes, rounds half away from
// zero, restores the sign and saturates; zero-frequency bins pass unscaled.
// Three register stages, the last being the output register.
// ----------------------------------------------------------------------------
module fbeq_scale
    import fbeq_pkg::*;
(
    input  logic                aclk,
    input  logic [2:0]          adv,
    input  logic [GAIN_W-1:0]   master_gain,
    input  logic [GAIN_W-1:0]   band_gain,
    input  side_t               side_s9,
    input  side_t               side_s10,
    output logic [IDX_W-1:0]    bin_out_reg,
    output logic [DATA_W-1:0]   real_out_reg,
    output logic [DATA_W-1:0]   imag_out_reg
);

    logic [TOTAL_W-1:0]  total_reg;
    logic [SCALED_W-1:0] scl_re_reg, scl_im_reg;
    logic [DATA_W-1:0]   real_out_next, imag_out_next;

    function automatic logic [DATA_W-1:0] round_sat(input logic [SCALED_W-1:0] scl,
                                                    input logic neg);
        logic [SCALED_W:0]   rnd;
        logic [SCALED_W-ROUND_SH:0] q;
        logic [DATA_W-1:0]   r;
        rnd = {1'b0, scl} + ((SCALED_W+1)'(1) << (ROUND_SH - 1));
        q   = rnd[SCALED_W:ROUND_SH];
        if (neg) begin
            if (q >= (SCALED_W-ROUND_SH+1)'(32768)) begin
                r = 16'h8000;
            end else begin
                r = ~q[DATA_W-1:0] + 16'd1;
            end
        end else if (q > (SCALED_W-ROUND_SH+1)'(32767)) begin
            r = 16'h7FFF;
        end else begin
            r = q[DATA_W-1:0];
        end
        return r;
    endfunction

    always_comb begin
        if (side_s10.kzero) begin
            real_out_next = side_s10.re;
            imag_out_next = side_s10.im;
        end else begin
            real_out_next = round_sat(scl_re_reg, side_s10.re[DATA_W-1]);
            imag_out_next = round_sat(scl_im_reg, side_s10.im[DATA_W-1]);
        end
    end

    always_ff @(posedge aclk) begin
        if (adv[0]) begin
            total_reg <= master_gain * band_gain;
        end
        if (adv[1]) begin
            scl_re_reg <= side_s9.mag_re * total_reg;
            scl_im_reg <= side_s9.mag_im * total_reg;
        end
        if (adv[2]) begin
            bin_out_reg  <= side_s10.idx;
            real_out_reg <= real_out_next;
            imag_out_reg <= imag_out_next;
        end
    end

endmodule

>>> design/fft_bin_graphic_equalizer.sv
// ----------------------------------------------------------------------------
// fft_bin_graphic_equalizer: ten-band octave equaliser on FFT bins
// Scales each nonzero-frequency complex bin by a master gain and a band
// gain interpolated between ten octave nodes from the folded bin frequency.
// ----------------------------------------------------------------------------
// Usage:
//   Input words (s_) carry one bin: index, real and imaginary part. Result
//   words (m_) carry the index and the scaled, saturated parts.
//   Gains, frequency step and FFT size are set through the write port
//   (cfg_wr_en, cfg_index, cfg_wdata) while no bins are in flight.
//   Throughput: one bin per clock while the output is not stalled. The
//   datapath has twelve stages (frequency multiply, segment search,
//   weighted products, constant divide by reciprocal multiply, gain
//   product, part scaling), the last of which is the output register.
//   Every stage carries a valid bit and advances when the stage after it is
//   empty or moving, so empty stages fill up while m_tready is low and
//   s_tready drops only once all twelve stages hold a word.
//   Reset (aresetn low at a clock edge) empties the pipeline and returns all
//   configuration registers to their defaults: unity gains, 96000 step, FFT size 1024.
// ----------------------------------------------------------------------------
module fft_bin_graphic_equalizer
    import fbeq_pkg::*;
#(
    parameter int MAX_FFT_LOG2 = 12
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  logic [TDATA_W-1:0]      s_tdata,   // bin_index, real_in, imag_in, pad
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output logic [TDATA_W-1:0]      m_tdata,   // bin_out, real_out, imag_out, pad
    input  logic                    cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]   cfg_wdata
);

    localparam int FW = MAX_FFT_LOG2 + HZ_W;

    logic [GAIN_W-1:0]     master_gain_reg;
    logic [63:0]           band_gains_low_reg;
    logic [63:0]           band_gains_mid_reg;
    logic [31:0]           band_gains_high_reg;
    logic [HZ_W-1:0]       hz_per_bin_reg;
    logic [LOG2_W-1:0]     fft_log2_reg;

    logic [NUM_STG-1:0]    vld_reg, vld_next, adv;
    side_t                 side_s0;
    side_t                 side_reg [1:NUM_STG-2];
    logic [FW-1:0]         freq;
    logic [GAIN_W-1:0]     band_gain;
    logic [IDX_W-1:0]      bin_out;
    logic [DATA_W-1:0]     real_out, imag_out;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            master_gain_reg     <= 16'd4096;
            band_gains_low_reg  <= 64'h1000_1000_1000_1000;
            band_gains_mid_reg  <= 64'h1000_1000_1000_1000;
            band_gains_high_reg <= 32'h1000_1000;
            hz_per_bin_reg      <= 24'd96000;
            fft_log2_reg        <= 4'd10;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_MASTER_GAIN: master_gain_reg     <= cfg_wdata[GAIN_W-1:0];
                REG_BAND_LOW:    band_gains_low_reg  <= cfg_wdata;
                REG_BAND_MID:    band_gains_mid_reg  <= cfg_wdata;
                REG_BAND_HIGH:   band_gains_high_reg <= cfg_wdata[31:0];
                REG_HZ_PER_BIN:  hz_per_bin_reg      <= cfg_wdata[HZ_W-1:0];
                REG_FFT_LOG2:    fft_log2_reg        <= cfg_wdata[LOG2_W-1:0];
                default: ;
            endcase
        end
    end

    // a stage may load when it is empty or its word moves on
    always_comb begin
        adv[NUM_STG-1] = !vld_reg[NUM_STG-1] || m_tready;
        for (int i = NUM_STG - 2; i >= 0; i--) begin
            adv[i] = !vld_reg[i] || adv[i+1];
        end
        vld_next = vld_reg;
        if (adv[0]) begin
            vld_next[0] = s_tvalid;
        end
        for (int i = 1; i < NUM_STG; i++) begin
            if (adv[i]) begin
                vld_next[i] = vld_reg[i-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv[1]) begin
            side_reg[1] <= side_s0;
        end
        for (int i = 2; i <= NUM_STG - 2; i++) begin
            if (adv[i]) begin
                side_reg[i] <= side_reg[i-1];
            end
        end
    end

    fbeq_fold #(
        .MAX_FFT_LOG2 (MAX_FFT_LOG2)
    ) u_fold (
        .aclk       (aclk),
        .adv        (adv[1:0]),
        .fft_log2   (fft_log2_reg),
        .hz_per_bin (hz_per_bin_reg),
        .bin_index  (s_tdata[11:0]),
        .real_in    (s_tdata[27:12]),
        .imag_in    (s_tdata[43:28]),
        .side_reg   (side_s0),
        .freq_reg   (freq)
    );

    fbeq_gain #(
        .FW (FW)
    ) u_gain (
        .aclk       (aclk),
        .adv        (adv[8:2]),
        .freq       (freq),
        .node_gains ({band_gains_high_reg, band_gains_mid_reg, band_gains_low_reg}),
        .gain_reg   (band_gain)
    );

    fbeq_scale u_scale (
        .aclk         (aclk),
        .adv          (adv[11:9]),
        .master_gain  (master_gain_reg),
        .band_gain    (band_gain),
        .side_s9      (side_reg[9]),
        .side_s10     (side_reg[10]),
        .bin_out_reg  (bin_out),
        .real_out_reg (real_out),
        .imag_out_reg (imag_out)
    );

    assign s_tready = adv[0];
    assign m_tvalid = vld_reg[NUM_STG-1];
    assign m_tdata  = {4'b0000, imag_out, real_out, bin_out};

endmodule

>>> design/fbeq_checker.sv
// ----------------------------------------------------------------------------
// fbeq_checker: port-level checks of the equaliser
// Watches reset, the output stall and the input ready of the top level.
// ----------------------------------------------------------------------------
module fbeq_checker
    import fbeq_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tready,
    input  logic                m_tvalid,
    input  logic                m_tready,
    input  logic [TDATA_W-1:0]  m_tdata
);

    // reset empties the pipeline
    assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result word present after reset");

    // hold a stalled result word
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result word changed or dropped");

    // with the output free, every stage can advance and input is taken
    assert property (@(posedge aclk) disable iff (!aresetn)
        (!m_tvalid || m_tready) |-> s_tready)
        else $error("input stalled while the output is free");

endmodule

bind fft_bin_graphic_equalizer fbeq_checker u_fbeq_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

>>> tb/fft_bin_graphic_equalizer_test.sv
// ----------------------------------------------------------------------------
// fft_bin_graphic_equalizer_test: self-checking bench for the bin equaliser
// Streams complex bins through the block under a range of gain, step and FFT
// size settings. Each accepted bin is predicted from a local model of the
// octave interpolation and part scaling, then compared field by field with
// the result words in order. A short table of directed bins comes first,
// then random phases with random sender and receiver idling and back-pressure.
// ----------------------------------------------------------------------------
module fft_bin_graphic_equalizer_test
    import fbeq_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int PHASES     = 12;
    localparam int PHASE_BINS = 120;

    // octave nodes in Q.12 Hz and the point where the top ramp reaches zero
    localparam logic [63:0] OCTAVE_Q12 [10] = '{
        64'd129024,   64'd258048,   64'd512000,   64'd1024000,  64'd2048000,
        64'd4096000,  64'd8192000,  64'd16384000, 64'd32768000, 64'd65536000
    };
    localparam logic [63:0] CUTOFF_Q12 = 64'd81920000;

    typedef struct packed {
        logic [IDX_W-1:0]  idx;
        logic [DATA_W-1:0] re;
        logic [DATA_W-1:0] im;
    } bin_t;

    typedef struct packed {
        logic                  is_reg;
        logic [CFG_ADDR_W-1:0] reg_idx;
        logic [CFG_DATA_W-1:0] reg_val;
        bin_t                  bin;
        logic                  typed;
        logic [DATA_W-1:0]     exp_re;
        logic [DATA_W-1:0]     exp_im;
    } stim_row_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [TDATA_W-1:0]    s_tdata   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [TDATA_W-1:0]    m_tdata;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    // local copy of the register file
    logic [15:0] master_gain = 16'h1000;
    logic [63:0] gains_low   = 64'h1000_1000_1000_1000;
    logic [63:0] gains_mid   = 64'h1000_1000_1000_1000;
    logic [31:0] gains_high  = 32'h1000_1000;
    logic [23:0] hz_step     = 24'd96000;
    logic [3:0]  fft_order   = 4'd10;

    // result typed into the directed table, travels with the input word
    logic              fixed_valid = 1'b0;
    logic [DATA_W-1:0] fixed_re    = '0;
    logic [DATA_W-1:0] fixed_im    = '0;

    bin_t      expected_bins [$];
    stim_row_t directed_rows [$];
    int        mismatches    = 0;
    int        send_idle_pct = 0;
    int        recv_idle_pct = 0;
    int        hold_request  = 0;
    int        hold_left     = 0;

    fft_bin_graphic_equalizer u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // ------------------------------------------------------------------ model

    function automatic logic [63:0] node_gain(int n);
        logic [63:0] g;
        if (n < 4)
            g = gains_low >> (16 * n);
        else if (n < 8)
            g = gains_mid >> (16 * (n - 4));
        else
            g = {32'd0, gains_high} >> (16 * (n - 8));
        return g & 64'hFFFF;
    endfunction

    function automatic logic [63:0] blend_gain(logic [63:0] glo, logic [63:0] ghi,
                                               logic [63:0] flo, logic [63:0] fhi,
                                               logic [63:0] f);
        logic [63:0] span;
        logic [63:0] d;
        span = fhi - flo;
        d    = f - flo;
        return (glo * (span - d) + ghi * d + span / 2) / span;
    endfunction

    function automatic logic [63:0] octave_gain(logic [63:0] f);
        if (f <= OCTAVE_Q12[0])
            return node_gain(0);
        for (int j = 1; j < 10; j++) begin
            if (f <= OCTAVE_Q12[j])
                return blend_gain(node_gain(j - 1), node_gain(j),
                                  OCTAVE_Q12[j - 1], OCTAVE_Q12[j], f);
        end
        // ramp from the top node down to zero at the cut-off
        if (f < CUTOFF_Q12)
            return blend_gain(node_gain(9), 64'd0, OCTAVE_Q12[9], CUTOFF_Q12, f);
        return 64'd0;
    endfunction

    function automatic logic [DATA_W-1:0] scale_part(logic [DATA_W-1:0] raw,
                                                     logic [63:0] total);
        logic [63:0] mag;
        logic [63:0] q;
        mag = raw[15] ? (64'd65536 - {48'd0, raw}) : {48'd0, raw};
        q   = (mag * total + 64'd8388608) >> 24;
        if (raw[15])
            return (q >= 64'd32768) ? 16'h8000 : 16'(64'd65536 - q);
        return (q > 64'd32767) ? 16'h7FFF : q[15:0];
    endfunction

    function automatic bin_t equalise_bin(bin_t b);
        bin_t        r;
        logic [3:0]  lg;
        logic [63:0] size;
        logic [63:0] k;
        logic [63:0] total;
        lg = fft_order;
        if (lg < 4'd2)
            lg = 4'd2;
        if (lg > 4'd12)
            lg = 4'd12;
        size = 64'd1 << lg;
        k    = {52'd0, b.idx} & (size - 1);
        r    = b;
        if (k == 64'd0)
            return r;
        // fold about the Nyquist bin
        if (k >= size / 2)
            k = size - k;
        total = {48'd0, master_gain} * octave_gain(k * {40'd0, hz_step});
        r.re  = scale_part(b.re, total);
        r.im  = scale_part(b.im, total);
        return r;
    endfunction

    function automatic logic [TDATA_W-1:0] pack_bin(bin_t b);
        return {4'd0, b.im, b.re, b.idx};
    endfunction

    function automatic bin_t unpack_bin(logic [TDATA_W-1:0] w);
        bin_t b;
        b.idx = w[11:0];
        b.re  = w[27:12];
        b.im  = w[43:28];
        return b;
    endfunction

    // --------------------------------------------------------------- checking

    task automatic report(string msg);
        if (mismatches < 10)
            $display("%t: %s", $realtime, msg);
        mismatches++;
    endtask

    always @(posedge aclk) begin
        bin_t got;
        bin_t want;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                got = unpack_bin(m_tdata);
                if (expected_bins.size() == 0) begin
                    report($sformatf("unexpected word: bin %0d re %0d im %0d",
                                     got.idx, $signed(got.re), $signed(got.im)));
                end else begin
                    want = expected_bins.pop_front();
                    if (got.idx !== want.idx)
                        report($sformatf("bin_out: expected %0d, got %0d",
                                         want.idx, got.idx));
                    if (got.re !== want.re)
                        report($sformatf("real_out bin %0d: expected %0d, got %0d",
                                         want.idx, $signed(want.re), $signed(got.re)));
                    if (got.im !== want.im)
                        report($sformatf("imag_out bin %0d: expected %0d, got %0d",
                                         want.idx, $signed(want.im), $signed(got.im)));
                end
            end
            if (s_tvalid && s_tready) begin
                want = equalise_bin(unpack_bin(s_tdata));
                if (fixed_valid) begin
                    want.re = fixed_re;
                    want.im = fixed_im;
                end
                expected_bins.push_back(want);
            end
        end
    end

    // --------------------------------------------------------------- receiver

    always @(negedge aclk) begin
        if (hold_request != 0) begin
            hold_left    = 60;
            hold_request = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // ----------------------------------------------------------------- sender

    // Called at a falling edge; returns at the falling edge after acceptance
    // with tvalid still high, so back-to-back words need no extra assignment.
    task automatic send_bin(bin_t b, logic typed, logic [15:0] er, logic [15:0] ei);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid    <= 1'b1;
        s_tdata     <= pack_bin(b);
        fixed_valid <= typed;
        fixed_re    <= er;
        fixed_im    <= ei;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (expected_bins.size() != 0)
            @(negedge aclk);
    endtask

    task automatic write_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            REG_MASTER_GAIN: master_gain = val[15:0];
            REG_BAND_LOW:    gains_low   = val;
            REG_BAND_MID:    gains_mid   = val;
            REG_BAND_HIGH:   gains_high  = val[31:0];
            REG_HZ_PER_BIN:  hz_step     = val[23:0];
            REG_FFT_LOG2:    fft_order   = val[3:0];
            default: ;
        endcase
        @(negedge aclk);
    endtask

    function automatic logic [15:0] pick_gain();
        case ($urandom_range(9))
            0, 1, 2: return 16'h1000;
            3:       return 16'hFFFF;
            4:       return 16'h0000;
            5, 6:    return 16'($urandom_range(0, 16'h2000));
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] pick_part();
        case ($urandom_range(15))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return 16'h0000;
            3:       return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [23:0] pick_step();
        case ($urandom_range(4))
            0:       return 24'd96000;
            1:       return 24'($urandom_range(1, 24'hFFFFFF));
            2:       return 24'($urandom_range(1, 400000));
            default: return 24'($urandom_range(20000, 200000));
        endcase
    endfunction

    task automatic add_bin(logic [11:0] idx, logic [15:0] re, logic [15:0] im,
                           logic typed, logic [15:0] er, logic [15:0] ei);
        stim_row_t row;
        row         = '0;
        row.bin.idx = idx;
        row.bin.re  = re;
        row.bin.im  = im;
        row.typed   = typed;
        row.exp_re  = er;
        row.exp_im  = ei;
        directed_rows.push_back(row);
    endtask

    task automatic add_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        stim_row_t row;
        row         = '0;
        row.is_reg  = 1'b1;
        row.reg_idx = idx;
        row.reg_val = val;
        directed_rows.push_back(row);
    endtask

    // ------------------------------------------------------------------- main

    initial begin
        stim_row_t row;
        bin_t      b;

        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        send_idle_pct = 38;
        recv_idle_pct = 70;

        // unity settings: every bin comes back unchanged
        add_bin(12'd0,    16'h7FFF, 16'h8000, 1'b1, 16'h7FFF, 16'h8000);
        add_bin(12'd1,    16'h8000, 16'h7FFF, 1'b1, 16'h8000, 16'h7FFF);
        add_bin(12'd512,  16'h3039, 16'hCFC7, 1'b1, 16'h3039, 16'hCFC7);
        add_bin(12'd1023, 16'h0001, 16'hFFFF, 1'b1, 16'h0001, 16'hFFFF);
        add_bin(12'd4095, 16'hFFFF, 16'h0001, 1'b1, 16'hFFFF, 16'h0001);
        add_bin(12'd1024, 16'h0064, 16'hFF9C, 1'b1, 16'h0064, 16'hFF9C);
        // full master gain saturates, bin 0 still passes
        add_reg(REG_MASTER_GAIN, 64'hFFFF);
        add_bin(12'd5,    16'h7FFF, 16'h8000, 1'b1, 16'h7FFF, 16'h8000);
        add_bin(12'd5,    16'h0001, 16'hFFFF, 1'b0, 16'h0, 16'h0);
        add_bin(12'd0,    16'h8000, 16'h7FFF, 1'b1, 16'h8000, 16'h7FFF);
        add_reg(REG_MASTER_GAIN, 64'h0);
        add_bin(12'd7,    16'h7FFF, 16'h8000, 1'b1, 16'h0000, 16'h0000);
        // largest step: beyond the cut-off, on the top ramp, between the top two nodes
        add_reg(REG_MASTER_GAIN, 64'h1000);
        add_reg(REG_HZ_PER_BIN, 64'hFF_FFFF);
        add_bin(12'd5,    16'h03E8, 16'hFC18, 1'b1, 16'h0000, 16'h0000);
        add_bin(12'd4,    16'h7530, 16'h8AD0, 1'b0, 16'h0, 16'h0);
        add_bin(12'd3,    16'h4E20, 16'hB1E0, 1'b0, 16'h0, 16'h0);
        // uneven node gains, smallest and zero step
        add_reg(REG_BAND_LOW,  64'hFFFF_0000_8000_0001);
        add_reg(REG_BAND_MID,  64'h0123_4567_89AB_CDEF);
        add_reg(REG_BAND_HIGH, 64'h2000_FFFF);
        add_reg(REG_HZ_PER_BIN, 64'd1);
        add_bin(12'd1,    16'h7FFF, 16'h8000, 1'b0, 16'h0, 16'h0);
        add_reg(REG_HZ_PER_BIN, 64'd0);
        add_bin(12'd300,  16'h4000, 16'hC000, 1'b0, 16'h0, 16'h0);
        // exactly on the cut-off, the top node, the first two nodes
        add_reg(REG_HZ_PER_BIN, 64'd16384000);
        add_bin(12'd5,    16'h1234, 16'hEDCC, 1'b1, 16'h0000, 16'h0000);
        add_bin(12'd4,    16'h1234, 16'hEDCC, 1'b0, 16'h0, 16'h0);
        add_reg(REG_HZ_PER_BIN, 64'd129024);
        add_bin(12'd1,    16'h2222, 16'hDDDE, 1'b0, 16'h0, 16'h0);
        add_bin(12'd2,    16'h2222, 16'hDDDE, 1'b0, 16'h0, 16'h0);
        // FFT size below and above the legal range, then the smallest legal size
        add_reg(REG_FFT_LOG2, 64'd0);
        add_bin(12'd4,    16'h1111, 16'hEEEF, 1'b1, 16'h1111, 16'hEEEF);
        add_bin(12'd6,    16'h1111, 16'hEEEF, 1'b0, 16'h0, 16'h0);
        add_reg(REG_FFT_LOG2, 64'd15);
        add_bin(12'd2049, 16'h5A5A, 16'hA5A5, 1'b0, 16'h0, 16'h0);
        add_bin(12'd2048, 16'h5A5A, 16'hA5A5, 1'b0, 16'h0, 16'h0);
        add_reg(REG_FFT_LOG2, 64'd2);
        add_bin(12'd3,    16'h5A5A, 16'hA5A5, 1'b0, 16'h0, 16'h0);

        foreach (directed_rows[i]) begin
            row = directed_rows[i];
            if (row.is_reg) begin
                wait_drained();
                write_reg(row.reg_idx, row.reg_val);
            end else begin
                send_bin(row.bin, row.typed, row.exp_re, row.exp_im);
            end
        end

        for (int p = 0; p < PHASES; p++) begin
            wait_drained();
            if (p == 0) begin
                write_reg(REG_MASTER_GAIN, 64'hFFFF);
                write_reg(REG_BAND_LOW,    '1);
                write_reg(REG_BAND_MID,    '1);
                write_reg(REG_BAND_HIGH,   64'hFFFF_FFFF);
                write_reg(REG_HZ_PER_BIN,  64'hFF_FFFF);
                write_reg(REG_FFT_LOG2,    64'd12);
            end else if (p == 1) begin
                write_reg(REG_MASTER_GAIN, 64'h0);
                write_reg(REG_BAND_LOW,    64'h0);
                write_reg(REG_BAND_MID,    64'h0);
                write_reg(REG_BAND_HIGH,   64'h0);
                write_reg(REG_HZ_PER_BIN,  64'd1);
                write_reg(REG_FFT_LOG2,    64'd2);
            end else begin
                write_reg(REG_MASTER_GAIN, {48'd0, pick_gain()});
                write_reg(REG_BAND_LOW,  {pick_gain(), pick_gain(), pick_gain(), pick_gain()});
                write_reg(REG_BAND_MID,  {pick_gain(), pick_gain(), pick_gain(), pick_gain()});
                write_reg(REG_BAND_HIGH, {32'd0, pick_gain(), pick_gain()});
                write_reg(REG_HZ_PER_BIN, {40'd0, pick_step()});
                write_reg(REG_FFT_LOG2, ($urandom_range(9) == 0) ?
                          64'($urandom_range(15)) : 64'($urandom_range(2, 12)));
            end

            if (p < 4) begin
                send_idle_pct = 38;
                recv_idle_pct = 70;
            end else if (p < 8) begin
                send_idle_pct = 70;
                recv_idle_pct = 38;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end

            for (int n = 0; n < PHASE_BINS; n++) begin
                // long receiver stall with the sender still pushing
                if (p == 9 && n == 10)
                    hold_request = 1;
                // let the pipeline empty completely mid-phase
                if (p == 5 && n == 60)
                    wait_drained();
                b.idx = ($urandom_range(19) == 0) ? 12'd0 : 12'($urandom_range(4095));
                b.re  = pick_part();
                b.im  = pick_part();
                send_bin(b, 1'b0, 16'h0, 16'h0);
            end
        end

        wait_drained();
        repeat (20) @(negedge aclk);
        if (mismatches == 0 && expected_bins.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

>>> fft_bin_graphic_equalizer.f
design/fbeq_pkg.sv
design/fbeq_fold.sv
design/fbeq_gain.sv
design/fbeq_scale.sv
design/fft_bin_graphic_equalizer.sv
design/fbeq_checker.sv
tb/fft_bin_graphic_equalizer_test.sv
